### src/alu8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8_pkg
// Types and constants shared by the 8-bit ALU pipeline: request and result
// payloads, operation codes and the word carried between pipeline stages.
// ----------------------------------------------------------------------------
package alu8_pkg;

    localparam int OPW = 8;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_ADD = 2'b00;
    localparam logic [1:0] MODE_SUB = 2'b01;
    localparam logic [1:0] MODE_MUL = 2'b10;
    localparam logic [1:0] MODE_DIV = 2'b11;

    // The restoring divider is spread evenly over this many stages.
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = OPW / DIV_STAGES;

    localparam logic [OPW-1:0] MIN_NEG   = 8'h80;
    localparam logic [OPW-1:0] MINUS_ONE = 8'hFF;

    typedef struct packed {
        logic [1:0]            mode;
        logic signed [OPW-1:0] operand_a;
        logic signed [OPW-1:0] operand_b;
        logic signed [OPW-1:0] operand_q;
    } alu8_req_t;

    typedef struct packed {
        logic signed [OPW-1:0] high_result;
        logic signed [OPW-1:0] low_result;
        logic                  overflow;
    } alu8_rsp_t;

    // Work word that travels down the pipeline with each request.
    typedef struct packed {
        logic [1:0]     mode;
        logic           use_div;  // divide with a nonzero divisor
        logic           neg_q;    // quotient must be negated at the end
        logic           neg_r;    // remainder must be negated at the end
        logic [OPW-1:0] hi;       // finished result for all other cases
        logic [OPW-1:0] lo;
        logic           ovf;
        logic [OPW-1:0] rem;      // partial remainder
        logic [OPW-1:0] quo;      // dividend bits shifting out, quotient in
        logic [OPW-1:0] dvsr;     // divisor magnitude
    } alu8_work_t;

endpackage

### src/alu8_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8_div_stage
// One register stage of the restoring divider. It performs DIV_STEPS
// shift-compare-subtract steps on the unsigned magnitudes and registers the
// work word with its valid bit.
// ----------------------------------------------------------------------------
module alu8_div_stage
    import alu8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  alu8_work_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output alu8_work_t out_data
);

    logic       valid_reg;
    logic       valid_next;
    alu8_work_t data_reg;
    alu8_work_t data_next;
    logic [OPW:0] trial;
    logic [OPW:0] diff;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next = in_data;
        trial     = '0;
        diff      = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {data_next.rem, data_next.quo[OPW-1]};
            diff  = trial - {1'b0, data_next.dvsr};
            if (!diff[OPW]) begin
                data_next.rem = diff[OPW-1:0];
                data_next.quo = {data_next.quo[OPW-2:0], 1'b1};
            end else begin
                data_next.rem = trial[OPW-1:0];
                data_next.quo = {data_next.quo[OPW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### src/alu8_add_sub_mul_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8_add_sub_mul_div
// Signed 8-bit ALU: add, subtract, full 16-bit multiply and truncating divide
// with a remainder that follows the dividend's sign.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless m_ready holds the output back;
// the eight restoring divide steps are split over four pipeline stages of
// two steps each, and that chain sets depth.
// Reset: aresetn (synchronous, active low) clears every stage's valid bit;
// data registers are not reset.
// ----------------------------------------------------------------------------
module alu8_add_sub_mul_div
    import alu8_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  alu8_req_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output alu8_rsp_t m_data
);

    // ------------------------------------------------------------------
    // Front stage. Add, subtract and multiply finish here; the divide
    // operands are reduced to magnitudes and the result signs are noted.
    // A zero divisor is resolved here too and bypasses the divider.
    // ------------------------------------------------------------------
    logic           a_valid_reg;
    logic           a_valid_next;
    alu8_work_t     a_data_reg;
    alu8_work_t     a_data_next;
    logic           a_ready;

    logic [OPW-1:0]   op_a;
    logic [OPW-1:0]   op_b;
    logic [OPW-1:0]   op_q;
    logic [OPW-1:0]   sum;
    logic [OPW-1:0]   dif;
    logic [2*OPW-1:0] prod;

    logic div_ready [DIV_STAGES+1];
    logic div_valid [DIV_STAGES+1];
    alu8_work_t div_data [DIV_STAGES+1];

    assign op_a = s_data.operand_a;
    assign op_b = s_data.operand_b;
    assign op_q = s_data.operand_q;
    assign sum  = op_a + op_b;
    assign dif  = op_a - op_b;
    // Sign-extended operands; the low 16 bits of the product are exact.
    assign prod = {{OPW{op_b[OPW-1]}}, op_b} * {{OPW{op_q[OPW-1]}}, op_q};

    always_comb begin
        a_data_next         = '0;
        a_data_next.mode    = s_data.mode;
        // Dividend magnitude starts in the quotient shifter; -128 maps to 128.
        a_data_next.quo     = op_q[OPW-1] ? (~op_q + 1'b1) : op_q;
        a_data_next.dvsr    = op_b[OPW-1] ? (~op_b + 1'b1) : op_b;
        a_data_next.neg_q   = op_q[OPW-1] ^ op_b[OPW-1];
        a_data_next.neg_r   = op_q[OPW-1];
        case (s_data.mode)
            MODE_ADD: begin
                a_data_next.hi  = sum;
                a_data_next.ovf = (op_a[OPW-1] == op_b[OPW-1]) &&
                                  (sum[OPW-1] != op_a[OPW-1]);
            end
            MODE_SUB: begin
                a_data_next.hi  = dif;
                a_data_next.ovf = (op_a[OPW-1] != op_b[OPW-1]) &&
                                  (dif[OPW-1] == op_b[OPW-1]);
            end
            MODE_MUL: begin
                a_data_next.hi = prod[2*OPW-1:OPW];
                a_data_next.lo = prod[OPW-1:0];
            end
            default: begin
                if (op_b == '0) begin
                    // Divide by zero returns the dividend and a quotient of one.
                    a_data_next.hi = op_q;
                    a_data_next.lo = OPW'(1);
                end else begin
                    a_data_next.use_div = 1'b1;
                    // Only -128 / -1 leaves the signed range.
                    a_data_next.ovf = (op_q == MIN_NEG) && (op_b == MINUS_ONE);
                end
            end
        endcase
    end

    assign a_ready = !a_valid_reg || div_ready[0];
    assign s_ready = a_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_ready) begin
            a_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && s_valid) begin
            a_data_reg <= a_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider pipeline. Every request walks through all stages so that
    // results leave in order; non-divide words simply ride along.
    // ------------------------------------------------------------------
    assign div_valid[0] = a_valid_reg;
    assign div_data[0]  = a_data_reg;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        alu8_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[g]),
            .in_ready  (div_ready[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_ready (div_ready[g+1]),
            .out_data  (div_data[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage. Applies the quotient and remainder signs and picks
    // the divider's answer or the value resolved in the front stage.
    // ------------------------------------------------------------------
    alu8_work_t     fin;
    logic [OPW-1:0] quo_s;
    logic [OPW-1:0] rem_s;
    alu8_rsp_t      o_data_next;
    alu8_rsp_t      o_data_reg;
    logic [1:0]     o_mode_reg;
    logic           o_valid_reg;
    logic           o_valid_next;
    logic           o_ready;

    assign fin   = div_data[DIV_STAGES];
    assign quo_s = fin.neg_q ? (~fin.quo + 1'b1) : fin.quo;
    assign rem_s = fin.neg_r ? (~fin.rem + 1'b1) : fin.rem;

    always_comb begin
        o_data_next.overflow = fin.ovf;
        if (fin.use_div) begin
            o_data_next.high_result = rem_s;
            o_data_next.low_result  = quo_s;
        end else begin
            o_data_next.high_result = fin.hi;
            o_data_next.low_result  = fin.lo;
        end
    end

    assign o_ready              = !o_valid_reg || m_ready;
    assign div_ready[DIV_STAGES] = o_ready;

    always_comb begin
        o_valid_next = o_valid_reg;
        if (o_ready) begin
            o_valid_next = div_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_ready && div_valid[DIV_STAGES]) begin
            o_data_reg <= o_data_next;
            o_mode_reg <= fin.mode;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_data  = o_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // With the output register empty, every stage's ready is high, so the
    // pipeline must take a new request.
    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("pipeline refused a request while the output was empty");

    // A multiply never reports overflow.
    a_mul_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && o_mode_reg == MODE_MUL) |-> !m_data.overflow)
        else $error("multiply flagged overflow");

    // The only divide overflow is -128 / -1, which wraps to -128 remainder 0.
    a_div_ovf_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && o_mode_reg == MODE_DIV && m_data.overflow) |->
        (m_data.low_result == MIN_NEG && m_data.high_result == '0))
        else $error("divide overflow with a wrong quotient or remainder");

    // Add and subtract leave the low byte at zero.
    a_addsub_low_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (o_mode_reg == MODE_ADD || o_mode_reg == MODE_SUB)) |->
        (m_data.low_result == '0))
        else $error("add or subtract produced a nonzero low byte");

endmodule

### test/alu8_add_sub_mul_div_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8_add_sub_mul_div_tb
// Self-checking bench for the pipelined 8-bit ALU. Requests go in through the
// s_ side and results come out of the m_ side. Each accepted request is run
// through a behavioral model of add, subtract, multiply and divide, and the
// expected result is queued. Every result that leaves the block is checked
// field by field against the oldest queued entry. The run covers corner
// operands, random traffic under several idle patterns, and a long output
// stall that backs the pipeline up.
// ----------------------------------------------------------------------------
module alu8_add_sub_mul_div_tb;
    import alu8_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 4;
    localparam int PIPE_LATENCY     = 5;
    localparam int RANDOM_PER_PHASE = 225;
    localparam int HOLD_OFF_CYCLES  = 200;
    localparam int PRESSURE_ITEMS   = 60;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    alu8_req_t s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    alu8_rsp_t m_data;

    // Percent chance, per cycle, that the sender or the receiver sits idle.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Bumping this counter asks the receiver process for one long hold-off.
    int unsigned hold_off_reqs = 0;

    // Results predicted for accepted requests, oldest first.
    alu8_rsp_t   pending_results[$];
    int unsigned mismatch_count = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    alu8_add_sub_mul_div dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Behavioral ALU. Integer arithmetic on sign-extended operands gives the
    // exact product, and the language's division already truncates toward
    // zero with the remainder following the dividend's sign.
    function automatic alu8_rsp_t compute_alu_result(input alu8_req_t req);
        alu8_rsp_t rsp;
        int        dividend;
        int        divisor;
        int        prod;
        int        quo;
        int        rem;
        rsp      = '0;
        dividend = req.operand_q;
        divisor  = req.operand_b;
        case (req.mode)
            MODE_ADD: begin
                rsp.high_result = req.operand_a + req.operand_b;
                rsp.overflow    = (req.operand_a[OPW-1] == req.operand_b[OPW-1]) &&
                                  (rsp.high_result[OPW-1] != req.operand_a[OPW-1]);
            end
            MODE_SUB: begin
                rsp.high_result = req.operand_a - req.operand_b;
                rsp.overflow    = (req.operand_a[OPW-1] != req.operand_b[OPW-1]) &&
                                  (rsp.high_result[OPW-1] == req.operand_b[OPW-1]);
            end
            MODE_MUL: begin
                prod            = divisor * dividend;
                rsp.high_result = prod[15:8];
                rsp.low_result  = prod[7:0];
            end
            default: begin
                if (divisor == 0) begin
                    // Divide by zero hands back the dividend with quotient one.
                    rsp.high_result = req.operand_q;
                    rsp.low_result  = 8'sd1;
                end else begin
                    quo             = dividend / divisor;
                    rem             = dividend % divisor;
                    rsp.low_result  = quo[7:0];
                    rsp.high_result = rem[7:0];
                    rsp.overflow    = (dividend == -128) && (divisor == -1);
                end
            end
        endcase
        return rsp;
    endfunction

    function automatic alu8_req_t make_req(input logic [1:0] mode,
                                           input logic signed [OPW-1:0] a,
                                           input logic signed [OPW-1:0] b,
                                           input logic signed [OPW-1:0] q);
        alu8_req_t req;
        req.mode      = mode;
        req.operand_a = a;
        req.operand_b = b;
        req.operand_q = q;
        return req;
    endfunction

    // Operands lean toward the values where sign and overflow handling break.
    function automatic logic signed [OPW-1:0] pick_operand();
        case ($urandom_range(7, 0))
            0:       return MIN_NEG;
            1:       return MINUS_ONE;
            2:       return '0;
            3:       return 8'sd1;
            4:       return 8'sh7F;
            default: return OPW'($urandom);
        endcase
    endfunction

    // Offers one request and returns at the clock edge that accepts it. The
    // valid line is only ever touched on a falling edge, once per edge, so a
    // back-to-back request keeps valid high without a glitch.
    task automatic send_request(input alu8_req_t req);
        @(negedge aclk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(compute_alu_result(req));
    endtask

    // Drops valid and waits until every predicted result has been seen.
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_add_sub_corners();
        send_request(make_req(MODE_ADD, 8'sh7F, 8'sd1, OPW'($urandom)));
        send_request(make_req(MODE_ADD, MIN_NEG, MINUS_ONE, OPW'($urandom)));
        send_request(make_req(MODE_ADD, '0, '0, OPW'($urandom)));
        send_request(make_req(MODE_ADD, MINUS_ONE, 8'sd1, OPW'($urandom)));
        send_request(make_req(MODE_ADD, 8'sh7F, MIN_NEG, OPW'($urandom)));
        send_request(make_req(MODE_SUB, MIN_NEG, 8'sd1, OPW'($urandom)));
        send_request(make_req(MODE_SUB, 8'sh7F, MINUS_ONE, OPW'($urandom)));
        send_request(make_req(MODE_SUB, '0, MIN_NEG, OPW'($urandom)));
        send_request(make_req(MODE_SUB, 8'sd5, 8'sd5, OPW'($urandom)));
        wait_for_results();
    endtask

    // A multiplicand of -128 is where a narrow Booth accumulator goes wrong.
    task automatic test_multiply_corners();
        send_request(make_req(MODE_MUL, OPW'($urandom), MIN_NEG, MIN_NEG));
        send_request(make_req(MODE_MUL, OPW'($urandom), MIN_NEG, 8'sh7F));
        send_request(make_req(MODE_MUL, OPW'($urandom), 8'sh7F, 8'sh7F));
        send_request(make_req(MODE_MUL, OPW'($urandom), MIN_NEG, '0));
        send_request(make_req(MODE_MUL, OPW'($urandom), MIN_NEG, MINUS_ONE));
        wait_for_results();
    endtask

    // Divisor goes in operand_b and dividend in operand_q.
    task automatic test_divide_corners();
        send_request(make_req(MODE_DIV, OPW'($urandom), MINUS_ONE, MIN_NEG));
        send_request(make_req(MODE_DIV, OPW'($urandom), '0, 8'sd7));
        send_request(make_req(MODE_DIV, OPW'($urandom), '0, MIN_NEG));
        send_request(make_req(MODE_DIV, OPW'($urandom), 8'sd1, MIN_NEG));
        send_request(make_req(MODE_DIV, OPW'($urandom), 8'sd2, -8'sd7));
        send_request(make_req(MODE_DIV, OPW'($urandom), -8'sd2, 8'sd7));
        send_request(make_req(MODE_DIV, OPW'($urandom), MIN_NEG, 8'sh7F));
        send_request(make_req(MODE_DIV, OPW'($urandom), MIN_NEG, MIN_NEG));
        send_request(make_req(MODE_DIV, OPW'($urandom), 8'sd5, '0));
        wait_for_results();
    endtask

    // Random operations under a given idle pattern. The percentages change on
    // a rising edge so the receiver, which reads them on falling edges, never
    // races the update.
    task automatic test_random_mix(input int count, input int unsigned send_pct,
                                   input int unsigned recv_pct);
        @(posedge aclk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            send_request(make_req(2'($urandom_range(3, 0)), pick_operand(),
                                  pick_operand(), pick_operand()));
        end
        wait_for_results();
    endtask

    // The receiver holds off long enough for the pipeline to fill, so s_ready
    // must drop while requests keep coming, and nothing may be lost or
    // duplicated once the output opens again.
    task automatic test_output_stall();
        @(posedge aclk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_reqs = hold_off_reqs + 1;
        repeat (PRESSURE_ITEMS) begin
            send_request(make_req(2'($urandom_range(3, 0)), OPW'($urandom),
                                  OPW'($urandom), OPW'($urandom)));
        end
        wait_for_results();
    endtask

    // Receiver: random ready, plus a long hold-off whenever one is asked for.
    // The hold-off length is counted here, on falling edges.
    initial begin
        int unsigned hold_off_served;
        int unsigned hold_left;
        hold_off_served = 0;
        hold_left       = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_served != hold_off_reqs) begin
                hold_off_served = hold_off_reqs;
                hold_left       = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    // Result checker: every accepted result must match the oldest prediction.
    always @(posedge aclk) begin
        alu8_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: high_result %0d low_result %0d overflow %0b",
                       m_data.high_result, m_data.low_result, m_data.overflow);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.high_result !== want.high_result) begin
                    $error("high_result: expected %0d, got %0d",
                           want.high_result, m_data.high_result);
                    mismatch_count++;
                end
                if (m_data.low_result !== want.low_result) begin
                    $error("low_result: expected %0d, got %0d",
                           want.low_result, m_data.low_result);
                    mismatch_count++;
                end
                if (m_data.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b",
                           want.overflow, m_data.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence. Reset is released on a falling edge, and then each test
    // runs to completion before the next one starts.
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_add_sub_corners();
        test_multiply_corners();
        test_divide_corners();
        test_random_mix(RANDOM_PER_PHASE, 7, 85);
        test_random_mix(RANDOM_PER_PHASE, 85, 7);
        test_random_mix(RANDOM_PER_PHASE, 0, 0);
        test_output_stall();

        // Give any stray result time to show up before the verdict.
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: a correct run finishes far sooner than this.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### files.f
src/alu8_pkg.sv
src/alu8_div_stage.sv
src/alu8_add_sub_mul_div.sv
test/alu8_add_sub_mul_div_tb.sv
